[hdl/pcse_pkg.sv]
// ----------------------------------------------------------------------------
// Polynomial coefficient store package
// Shared constants, command codes, controller states and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package pcse_pkg;

	localparam int MAX_TERMS  = 128;
	localparam int IDX_W      = $clog2(MAX_TERMS);
	localparam int DATA_W     = 32;
	localparam int TERM_IDX_W = 7;
	localparam int CMD_W      = 3;

	typedef enum logic [CMD_W-1:0] {
		CMD_SET    = 3'd0,
		CMD_ADD    = 3'd1,
		CMD_READ   = 3'd2,
		CMD_CLEAR  = 3'd3,
		CMD_RELOAD = 3'd4,
		CMD_EVAL   = 3'd5,
		CMD_DEGREE = 3'd6
	} pcse_cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SET,
		ST_RD,
		ST_ADD,
		ST_READ,
		ST_CLEAR,
		ST_RELOAD,
		ST_EV_START,
		ST_EV_MUL,
		ST_EV_ADD,
		ST_DEG_START,
		ST_DEG_CHK,
		ST_FIN
	} pcse_state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CAPTURE,
		OP_SET,
		OP_ADD,
		OP_READ,
		OP_CLEAR,
		OP_RELOAD,
		OP_EV_MUL,
		OP_EV_ADD,
		OP_DEG_CHK,
		OP_LOAD_OUT
	} pcse_op_t;

	typedef struct packed {
		pcse_op_t op;
		logic     sel_cnt;
		logic     cnt_init;
		logic     cnt_step;
	} pcse_ctl_t;

	typedef struct packed {
		pcse_cmd_t cmd;
		logic      ev_last;
		logic      deg_stop;
	} pcse_sts_t;

endpackage

[hdl/pcse_if.sv]
// ----------------------------------------------------------------------------
// Polynomial coefficient store channels
// Valid/ready channels for commands into the block and results out of it.
// ----------------------------------------------------------------------------
interface pcse_in_if;
	logic               valid;
	logic               ready;
	logic [2:0]         cmd;
	logic [6:0]         term_index;
	logic signed [31:0] coefficient;
	logic signed [31:0] eval_point;

	modport source (output valid, output cmd, output term_index, output coefficient,
		output eval_point, input ready);
	modport sink (input valid, input cmd, input term_index, input coefficient,
		input eval_point, output ready);
endinterface

interface pcse_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] value;
	logic               overflow;

	modport source (output valid, output value, output overflow, input ready);
	modport sink (input valid, input value, input overflow, output ready);
endinterface

[hdl/pcse_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pcse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

[hdl/pcse_ctrl.sv]
// ----------------------------------------------------------------------------
// Polynomial coefficient store controller
// Sequences each command through the datapath and owns the result valid.
// ----------------------------------------------------------------------------
module pcse_ctrl import pcse_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output pcse_ctl_t ctl,
	input  pcse_sts_t sts
);

	pcse_state_t state_q;
	pcse_state_t state_d;
	logic        out_valid_q;
	logic        out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				case (sts.cmd)
					CMD_SET:    state_d = ST_SET;
					CMD_ADD:    state_d = ST_RD;
					CMD_READ:   state_d = ST_RD;
					CMD_CLEAR:  state_d = ST_CLEAR;
					CMD_RELOAD: state_d = ST_RELOAD;
					CMD_EVAL:   state_d = ST_EV_START;
					CMD_DEGREE: state_d = ST_DEG_START;
					default:    state_d = ST_FIN;
				endcase
			end
			ST_RD: begin
				state_d = (sts.cmd == CMD_ADD) ? ST_ADD : ST_READ;
			end
			ST_SET, ST_ADD, ST_READ, ST_CLEAR, ST_RELOAD: begin
				state_d = ST_FIN;
			end
			ST_EV_START: begin
				state_d = ST_EV_MUL;
			end
			ST_EV_MUL: begin
				state_d = ST_EV_ADD;
			end
			ST_EV_ADD: begin
				state_d = sts.ev_last ? ST_FIN : ST_EV_MUL;
			end
			ST_DEG_START: begin
				state_d = ST_DEG_CHK;
			end
			ST_DEG_CHK: begin
				if (sts.deg_stop) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl = '{op: OP_NONE, sel_cnt: 1'b0, cnt_init: 1'b0, cnt_step: 1'b0};
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					ctl.op = OP_CAPTURE;
				end
			end
			ST_DECODE: begin
				ctl.cnt_init = 1'b1;
			end
			ST_SET: begin
				ctl.op = OP_SET;
			end
			ST_ADD: begin
				ctl.op = OP_ADD;
			end
			ST_READ: begin
				ctl.op = OP_READ;
			end
			ST_CLEAR: begin
				ctl.op = OP_CLEAR;
			end
			ST_RELOAD: begin
				ctl.op = OP_RELOAD;
			end
			ST_EV_START, ST_DEG_START: begin
				ctl.sel_cnt  = 1'b1;
				ctl.cnt_step = 1'b1;
			end
			ST_EV_MUL: begin
				ctl.op      = OP_EV_MUL;
				ctl.sel_cnt = 1'b1;
			end
			ST_EV_ADD: begin
				ctl.op       = OP_EV_ADD;
				ctl.sel_cnt  = 1'b1;
				ctl.cnt_step = 1'b1;
			end
			ST_DEG_CHK: begin
				ctl.op       = OP_DEG_CHK;
				ctl.sel_cnt  = 1'b1;
				ctl.cnt_step = 1'b1;
			end
			ST_FIN: begin
				if (out_free) begin
					ctl.op = OP_LOAD_OUT;
				end
			end
			default: begin
				ctl.op = OP_NONE;
			end
		endcase
	end

endmodule

[hdl/pcse_dp.sv]
// ----------------------------------------------------------------------------
// Polynomial coefficient store datapath
// Coefficient memory with per-entry valid bits, Horner multiply-add, degree
// scan and the result register.
// ----------------------------------------------------------------------------
module pcse_dp import pcse_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  pcse_ctl_t               ctl,
	output pcse_sts_t               sts,
	input  logic [CMD_W-1:0]        in_cmd,
	input  logic [TERM_IDX_W-1:0]   in_term_index,
	input  logic signed [DATA_W-1:0] in_coefficient,
	input  logic signed [DATA_W-1:0] in_eval_point,
	output logic signed [DATA_W-1:0] out_value,
	output logic                    out_overflow
);

	pcse_cmd_t                 cmd_q;
	logic [IDX_W-1:0]          idx_q;
	logic                      in_range_q;
	logic signed [DATA_W-1:0]  coef_q;
	logic signed [DATA_W-1:0]  x_q;
	logic signed [DATA_W-1:0]  acc_q;
	logic [IDX_W-1:0]          cnt_q;
	logic [IDX_W-1:0]          rd_addr_q;
	logic [MAX_TERMS-1:0]      valid_q;
	logic signed [2*DATA_W-1:0] prod_s1;
	logic [DATA_W-1:0]         term_s1;
	logic                      last_s1;
	logic                      ovf_q;
	logic [DATA_W-1:0]         res_q;
	logic [DATA_W-1:0]         out_value_q;
	logic                      out_ovf_q;

	logic [IDX_W-1:0]          rd_addr;
	logic [DATA_W-1:0]         rd_data;
	logic [DATA_W-1:0]         term;
	logic                      wr_en;
	logic [IDX_W-1:0]          wr_addr;
	logic [DATA_W-1:0]         wr_data;
	logic [DATA_W:0]           add_sum;
	logic                      add_ovf;
	logic [DATA_W:0]           ev_sum;
	logic                      ev_ovf;
	logic                      prod_ovf;
	logic                      deg_hit;

	assign rd_addr = ctl.sel_cnt ? cnt_q : idx_q;

	pcse_ram #(
		.WIDTH(DATA_W),
		.DEPTH(MAX_TERMS)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// An entry whose valid bit is clear reads as its reset value.
	assign term = valid_q[rd_addr_q] ? rd_data :
		((rd_addr_q == '0) ? DATA_W'(1) : '0);

	assign add_sum  = {term[DATA_W-1], term} + {coef_q[DATA_W-1], coef_q};
	assign add_ovf  = add_sum[DATA_W] ^ add_sum[DATA_W-1];
	assign prod_ovf = (prod_s1[2*DATA_W-1:DATA_W-1] != {(DATA_W+1){prod_s1[DATA_W-1]}});
	assign ev_sum   = {prod_s1[DATA_W-1], prod_s1[DATA_W-1:0]} + {term_s1[DATA_W-1], term_s1};
	assign ev_ovf   = ev_sum[DATA_W] ^ ev_sum[DATA_W-1];
	assign deg_hit  = (term != '0) && (rd_addr_q != '0);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = coef_q;
		case (ctl.op)
			OP_SET, OP_RELOAD: begin
				wr_en = in_range_q;
			end
			OP_ADD: begin
				wr_en   = in_range_q;
				wr_data = add_sum[DATA_W-1:0];
			end
			OP_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = '0;
				wr_data = '0;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			case (ctl.op)
				OP_SET, OP_ADD: begin
					if (in_range_q) begin
						valid_q[idx_q] <= 1'b1;
					end
				end
				OP_CLEAR: begin
					valid_q <= MAX_TERMS'(1);
				end
				OP_RELOAD: begin
					valid_q <= in_range_q ? (MAX_TERMS'(1) << idx_q) : '0;
				end
				default: begin
					valid_q <= valid_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_addr_q <= rd_addr;
		if (ctl.cnt_init) begin
			cnt_q <= IDX_W'(MAX_TERMS - 1);
		end else if (ctl.cnt_step && cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
		case (ctl.op)
			OP_CAPTURE: begin
				cmd_q      <= pcse_cmd_t'(in_cmd);
				idx_q      <= IDX_W'(in_term_index);
				in_range_q <= (32'(in_term_index) < 32'(MAX_TERMS));
				coef_q     <= in_coefficient;
				x_q        <= in_eval_point;
				acc_q      <= '0;
				ovf_q      <= 1'b0;
				res_q      <= '0;
			end
			OP_ADD: begin
				ovf_q <= in_range_q && add_ovf;
			end
			OP_READ: begin
				res_q <= in_range_q ? term : '0;
			end
			OP_EV_MUL: begin
				prod_s1 <= acc_q * x_q;
				term_s1 <= term;
				last_s1 <= (rd_addr_q == '0);
			end
			OP_EV_ADD: begin
				acc_q <= ev_sum[DATA_W-1:0];
				res_q <= ev_sum[DATA_W-1:0];
				ovf_q <= ovf_q | prod_ovf | ev_ovf;
			end
			OP_DEG_CHK: begin
				if (deg_hit) begin
					res_q <= DATA_W'(rd_addr_q);
				end
			end
			OP_LOAD_OUT: begin
				out_value_q <= res_q;
				out_ovf_q   <= ovf_q;
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	assign sts = '{cmd: cmd_q, ev_last: last_s1, deg_stop: deg_hit || (rd_addr_q == '0)};

	assign out_value    = out_value_q;
	assign out_overflow = out_ovf_q;

endmodule

[hdl/polynomial_coefficient_store_eval_unit.sv]
// ----------------------------------------------------------------------------
// Polynomial coefficient store and evaluator
// Keeps one signed 32-bit coefficient per power of x and runs set, add, read,
// clear, reload, degree and Horner evaluation commands, one result each.
// ----------------------------------------------------------------------------
// The block takes one command at a time and returns exactly one result for
// it. The degree scan walks down from the top entry and stops at the highest
// nonzero coefficient above entry zero, or at entry zero, while evaluation
// always walks every coefficient. Evaluation runs the Horner loop, with a
// multiply state and an add state for every coefficient read from the
// coefficient memory with its registered read port; the degree scan reads one
// coefficient per cycle. A new command may be accepted while the previous
// result still waits in the output register. Reset gives entry zero the value
// one and all others zero, with no clearing pass. Arithmetic wraps to 32 bits
// and the overflow bit reports any wrap in the command's products or sums.
module polynomial_coefficient_store_eval_unit import pcse_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	pcse_in_if.sink    req,
	pcse_out_if.source rsp
);

	pcse_ctl_t ctl;
	pcse_sts_t sts;

	pcse_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.out_valid(rsp.valid),
		.out_ready(rsp.ready),
		.ctl      (ctl),
		.sts      (sts)
	);

	pcse_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.sts           (sts),
		.in_cmd        (req.cmd),
		.in_term_index (req.term_index),
		.in_coefficient(req.coefficient),
		.in_eval_point (req.eval_point),
		.out_value     (rsp.value),
		.out_overflow  (rsp.overflow)
	);

endmodule

[hdl/pcse_checker.sv]
// ----------------------------------------------------------------------------
// Polynomial coefficient store checker
// Port-level checks on command and result transfers.
// ----------------------------------------------------------------------------
module pcse_checker import pcse_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic [CMD_W-1:0]  in_cmd,
	input logic              out_valid,
	input logic              out_ready,
	input logic [DATA_W-1:0] out_value,
	input logic              out_overflow
);

	logic             in_xfer;
	logic             out_xfer;
	logic [1:0]       outst_q;
	logic [CMD_W-1:0] pend_cmd_q;

	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outst_q <= '0;
		end else begin
			outst_q <= outst_q + {1'b0, in_xfer} - {1'b0, out_xfer};
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			pend_cmd_q <= in_cmd;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_overflow))
		else $error("result changed or dropped while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !in_ready)
		else $error("command accepted while another was in progress");

	a_outst_bound: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |-> outst_q < 2'd2)
		else $error("more than one result waiting on a new command");

	a_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && outst_q == 2'd1 && (pend_cmd_q == CMD_SET || pend_cmd_q == CMD_CLEAR ||
		pend_cmd_q == CMD_RELOAD) |-> out_value == '0 && !out_overflow)
		else $error("write command returned a nonzero result");

endmodule

bind polynomial_coefficient_store_eval_unit pcse_checker u_pcse_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (req.valid),
	.in_ready    (req.ready),
	.in_cmd      (req.cmd),
	.out_valid   (rsp.valid),
	.out_ready   (rsp.ready),
	.out_value   (rsp.value),
	.out_overflow(rsp.overflow)
);

[bench/polynomial_coefficient_store_eval_unit_test.sv]
// ----------------------------------------------------------------------------
// Polynomial coefficient store and evaluator testbench
// Drives set, add-to, read, clear, reload, degree and evaluate commands with
// bursty transfers and a stalling receiver, predicts every result from a
// private copy of the coefficient table, and checks value and overflow.
// ----------------------------------------------------------------------------
module polynomial_coefficient_store_eval_unit_test;
	import pcse_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
	localparam int IDLE_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 16;
	localparam int RANDOM_ITEMS = 900;
	localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7fffffff;
	localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh80000000;

	typedef struct packed {
		logic [CMD_W-1:0]         cmd;
		logic [TERM_IDX_W-1:0]    term_index;
		logic signed [DATA_W-1:0] coefficient;
		logic signed [DATA_W-1:0] eval_point;
	} poly_cmd_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     overflow;
	} poly_answer_t;

	logic clk;
	logic arst_n;

	pcse_in_if  req();
	pcse_out_if rsp();

	logic signed [DATA_W-1:0] coef_copy [MAX_TERMS];
	poly_answer_t answers_due [$];
	int error_count;
	int idle_cycles;
	int burst_left;
	bit draining;

	polynomial_coefficient_store_eval_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic signed [DATA_W-1:0] wrap_tracked(input longint exact,
		inout logic ovf);
		if (exact > longint'(S32_MAX) || exact < longint'(S32_MIN))
			ovf = 1'b1;
		return exact[DATA_W-1:0];
	endfunction

	function automatic poly_answer_t answer_for(input poly_cmd_t c);
		poly_answer_t a;
		logic signed [DATA_W-1:0] acc;
		logic signed [DATA_W-1:0] prod;
		logic ovf;
		bit in_range;
		ovf = 1'b0;
		a.value = '0;
		in_range = int'(c.term_index) < MAX_TERMS;
		case (c.cmd)
			CMD_SET: begin
				if (in_range)
					coef_copy[c.term_index] = c.coefficient;
			end
			CMD_ADD: begin
				if (in_range)
					coef_copy[c.term_index] = wrap_tracked(longint'(coef_copy[c.term_index])
						+ longint'(c.coefficient), ovf);
			end
			CMD_READ: begin
				if (in_range)
					a.value = coef_copy[c.term_index];
			end
			CMD_CLEAR: begin
				foreach (coef_copy[i])
					coef_copy[i] = '0;
			end
			CMD_RELOAD: begin
				foreach (coef_copy[i])
					coef_copy[i] = '0;
				coef_copy[0] = 1;
				if (in_range)
					coef_copy[c.term_index] = c.coefficient;
			end
			CMD_EVAL: begin
				acc = '0;
				for (int i = MAX_TERMS - 1; i >= 0; i--) begin
					prod = wrap_tracked(longint'(acc) * longint'(c.eval_point), ovf);
					acc = wrap_tracked(longint'(prod) + longint'(coef_copy[i]), ovf);
				end
				a.value = acc;
			end
			CMD_DEGREE: begin
				for (int i = MAX_TERMS - 1; i > 0; i--) begin
					if (coef_copy[i] != 0) begin
						a.value = i;
						break;
					end
				end
			end
			default: begin
			end
		endcase
		a.overflow = ovf;
		return a;
	endfunction

	function automatic poly_cmd_t make_cmd(input logic [CMD_W-1:0] cmd,
		input int unsigned idx, input logic signed [DATA_W-1:0] coef,
		input logic signed [DATA_W-1:0] point);
		poly_cmd_t c;
		c.cmd = cmd;
		c.term_index = idx[TERM_IDX_W-1:0];
		c.coefficient = coef;
		c.eval_point = point;
		return c;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		error_count++;
	endtask

	// The sender works in bursts; valid is only lowered when a real gap follows.
	task automatic send_command(input poly_cmd_t c);
		int gap;
		req.cmd = c.cmd;
		req.term_index = c.term_index;
		req.coefficient = c.coefficient;
		req.eval_point = c.eval_point;
		req.valid = 1'b1;
		do
			@(posedge clk);
		while (req.ready !== 1'b1);
		answers_due.push_back(answer_for(c));
		@(negedge clk);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				req.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	endtask

	task automatic test_reset_contents;
		send_command(make_cmd(CMD_READ, 0, 0, 0));
		send_command(make_cmd(CMD_DEGREE, 0, 0, 0));
		send_command(make_cmd(CMD_EVAL, 0, 0, S32_MAX));
	endtask

	task automatic test_set_and_read;
		send_command(make_cmd(CMD_SET, 127, S32_MAX, 0));
		send_command(make_cmd(CMD_READ, 127, 0, 0));
		send_command(make_cmd(CMD_SET, 1, S32_MIN, 0));
		send_command(make_cmd(CMD_READ, 1, 0, 0));
		send_command(make_cmd(CMD_READ, 64, 0, 0));
	endtask

	task automatic test_add_to;
		send_command(make_cmd(CMD_ADD, 127, 1, 0));
		send_command(make_cmd(CMD_ADD, 1, -1, 0));
		send_command(make_cmd(CMD_ADD, 2, 32'sh12345678, 0));
	endtask

	task automatic test_degree_scan;
		send_command(make_cmd(CMD_DEGREE, 0, 0, 0));
	endtask

	task automatic test_evaluate;
		send_command(make_cmd(CMD_EVAL, 0, 0, 0));
		send_command(make_cmd(CMD_EVAL, 0, 0, -1));
		send_command(make_cmd(CMD_EVAL, 0, 0, S32_MIN));
	endtask

	task automatic test_clear_and_reload;
		send_command(make_cmd(CMD_CLEAR, 0, 0, 0));
		send_command(make_cmd(CMD_DEGREE, 0, 0, 0));
		send_command(make_cmd(CMD_RELOAD, 0, -7, 0));
		send_command(make_cmd(CMD_READ, 0, 0, 0));
		send_command(make_cmd(CMD_RELOAD, 64, 32'shA5A5A5A5, 0));
		send_command(make_cmd(CMD_DEGREE, 0, 0, 0));
		send_command(make_cmd(CMD_EVAL, 0, 0, 1));
	endtask

	task automatic test_unused_code;
		send_command(make_cmd(CMD_UNUSED, 127, -1, -1));
	endtask

	// Mostly small indices, coefficients and points keep the low entries of the
	// table dense; extreme and random values mix in, and wraps are predicted too.
	task automatic test_random_mix(input int count);
		poly_cmd_t c;
		int r;
		repeat (count) begin
			r = $urandom_range(0, 99);
			if (r < 25)
				c.cmd = CMD_SET;
			else if (r < 46)
				c.cmd = CMD_ADD;
			else if (r < 60)
				c.cmd = CMD_READ;
			else if (r < 73)
				c.cmd = CMD_EVAL;
			else if (r < 85)
				c.cmd = CMD_DEGREE;
			else if (r < 88)
				c.cmd = CMD_CLEAR;
			else if (r < 95)
				c.cmd = CMD_RELOAD;
			else
				c.cmd = CMD_UNUSED;
			c.term_index = ($urandom_range(0, 9) < 7) ? TERM_IDX_W'($urandom_range(0, 7))
				: TERM_IDX_W'($urandom);
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: c.coefficient = $urandom_range(0, 8) - 4;
				5, 6: c.coefficient = $urandom_range(0, 1) ? S32_MAX - $urandom_range(0, 2)
					: S32_MIN + $urandom_range(0, 2);
				default: c.coefficient = $urandom;
			endcase
			case ($urandom_range(0, 9))
				0, 1, 2, 3: c.eval_point = $urandom_range(0, 4) - 2;
				4, 5, 6: c.eval_point = $urandom_range(0, 32) - 16;
				default: c.eval_point = $urandom;
			endcase
			send_command(c);
		end
	endtask

	initial begin
		rsp.ready = 1'b0;
		forever begin
			if (draining) begin
				rsp.ready = 1'b1;
				@(negedge clk);
			end else if ($urandom_range(0, 7) == 0) begin
				rsp.ready = 1'b1;
				repeat ($urandom_range(50, 200)) @(negedge clk);
			end else begin
				rsp.ready = 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
				rsp.ready = 1'b1;
				repeat ($urandom_range(1, 10)) @(negedge clk);
			end
		end
	end

	always @(posedge clk) begin : check_results
		poly_answer_t want;
		if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
			if (answers_due.size() == 0) begin
				report_mismatch($sformatf("unexpected transfer: value %0d overflow %0b",
					rsp.value, rsp.overflow));
			end else begin
				want = answers_due.pop_front();
				if (rsp.value !== want.value)
					report_mismatch($sformatf("value %0d, predicted %0d",
						rsp.value, want.value));
				if (rsp.overflow !== want.overflow)
					report_mismatch($sformatf("overflow %0b, predicted %0b",
						rsp.overflow, want.overflow));
			end
		end
	end

	always @(posedge clk) begin
		if ((req.valid === 1'b1 && req.ready === 1'b1)
			|| (rsp.valid === 1'b1 && rsp.ready === 1'b1))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		error_count = 0;
		idle_cycles = 0;
		burst_left = 1;
		draining = 1'b0;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.cmd = CMD_SET;
		req.term_index = '0;
		req.coefficient = '0;
		req.eval_point = '0;
		foreach (coef_copy[i])
			coef_copy[i] = '0;
		coef_copy[0] = 1;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_contents();
		test_set_and_read();
		test_add_to();
		test_degree_scan();
		test_evaluate();
		test_clear_and_reload();
		test_unused_code();
		test_random_mix(RANDOM_ITEMS);

		req.valid = 1'b0;
		draining = 1'b1;
		while (answers_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

[filelist.f]
hdl/pcse_pkg.sv
hdl/pcse_if.sv
hdl/pcse_ram.sv
hdl/pcse_ctrl.sv
hdl/pcse_dp.sv
hdl/polynomial_coefficient_store_eval_unit.sv
hdl/pcse_checker.sv
bench/polynomial_coefficient_store_eval_unit_test.sv
